/* sv/sclen_pkg.sv */
// Shared types and constants for the sound channel length and envelope core.
package sclen_pkg;

    typedef logic [2:0] kind_t;

    localparam kind_t KIND_TICK       = 3'd0;
    localparam kind_t KIND_VOLUME     = 3'd1;
    localparam kind_t KIND_LENGTH     = 3'd2;
    localparam kind_t KIND_LENGTH_EN  = 3'd3;
    localparam kind_t KIND_ENVELOPE   = 3'd4;
    localparam kind_t KIND_TRIGGER    = 3'd5;
    localparam kind_t KIND_CHANNEL_EN = 3'd6;

    localparam int VALUE_W   = 7;
    localparam int VOL_W     = 4;
    localparam int PERIOD_W  = 3;
    localparam int PHASE_W   = 2;
    localparam int IN_DATA_W = 16;
    localparam int OUT_W     = 24;

    localparam logic [VOL_W-1:0] VOL_MAX = 4'd15;

endpackage

/* sv/sound_channel_length_envelope_core.sv */
// Sound channel length counter, volume envelope and enable flags.
// A request accepted on the input passes the input register, then the
// result register, from which its answer is presented.
// Throughput: one request per cycle while m_axis_tready does not stall the output.
// Reset (rst_n low, asynchronous) restores the power-on channel state and
// empties both register stages.
module sound_channel_length_envelope_core #(
    parameter int LENGTH_LIMIT = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // Bits from low: value[6:0], flag[7], first_half[8], zero fill.
    input  logic [sclen_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // Bits from low: kind[2:0].
    input  logic [2:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // Bits from low: level[3:0], current_volume[7:4], channel_active[8],
    // dac_active[9], length_remaining[16:10], zero fill.
    output logic [sclen_pkg::OUT_W-1:0]      m_axis_tdata
);

    localparam int LW = $clog2(LENGTH_LIMIT + 1);
    localparam int CW = (LW > sclen_pkg::VALUE_W) ? LW : sclen_pkg::VALUE_W;
    localparam logic [LW-1:0] LIMIT_W = LW'(LENGTH_LIMIT);
    localparam logic [CW-1:0] LIMIT_C = CW'(LENGTH_LIMIT);

    // Input register.
    logic                               in_valid_reg;
    sclen_pkg::kind_t                   kind_reg;
    logic [sclen_pkg::VALUE_W-1:0]      value_reg;
    logic                               flag_reg;
    logic                               first_half_reg;

    // Result register.
    logic                               out_valid_reg;
    logic [sclen_pkg::OUT_W-1:0]        out_data_reg;
    logic [sclen_pkg::OUT_W-1:0]        out_data_next;

    // Channel state.
    logic                               chan_on_reg, chan_on_next;
    logic                               dac_on_reg, dac_on_next;
    logic                               length_on_reg, length_on_next;
    logic                               just_en_reg, just_en_next;
    logic [LW-1:0]                      length_left_reg, length_left_next;
    logic [sclen_pkg::VOL_W-1:0]        vol_reg, vol_next;
    logic [sclen_pkg::VOL_W-1:0]        start_vol_reg, start_vol_next;
    logic [sclen_pkg::PERIOD_W-1:0]     env_period_reg, env_period_next;
    logic                               env_up_reg, env_up_next;
    logic [sclen_pkg::PERIOD_W-1:0]     env_count_reg, env_count_next;
    logic [sclen_pkg::PHASE_W-1:0]      phase_reg, phase_next;

    logic                               advance;
    logic                               do_tick;
    logic [CW-1:0]                      value_ext;
    logic [LW-1:0]                      load_sat;
    logic [sclen_pkg::VOL_W-1:0]        level;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign value_ext = CW'(value_reg);
    assign load_sat  = (value_ext > LIMIT_C) ? LIMIT_W : LW'(value_ext);

    always_comb
    begin
        chan_on_next     = chan_on_reg;
        dac_on_next      = dac_on_reg;
        length_on_next   = length_on_reg;
        just_en_next     = just_en_reg;
        length_left_next = length_left_reg;
        vol_next         = vol_reg;
        start_vol_next   = start_vol_reg;
        env_period_next  = env_period_reg;
        env_up_next      = env_up_reg;
        env_count_next   = env_count_reg;
        phase_next       = phase_reg;
        do_tick          = 1'b0;

        // Event-specific updates that come before any sequencer tick.
        case (kind_reg)
            sclen_pkg::KIND_TICK:
            begin
                do_tick = 1'b1;
            end
            sclen_pkg::KIND_VOLUME:
            begin
                vol_next       = value_reg[sclen_pkg::VOL_W-1:0];
                start_vol_next = value_reg[sclen_pkg::VOL_W-1:0];
                if (flag_reg)
                begin
                    if (value_reg[sclen_pkg::VOL_W-1:0] == '0 && !env_up_reg)
                    begin
                        dac_on_next  = 1'b0;
                        chan_on_next = 1'b0;
                    end
                    else
                    begin
                        dac_on_next = 1'b1;
                    end
                end
            end
            sclen_pkg::KIND_LENGTH:
            begin
                length_left_next = LIMIT_W - load_sat;
            end
            sclen_pkg::KIND_LENGTH_EN:
            begin
                length_on_next = flag_reg;
                just_en_next   = !length_on_reg && flag_reg;
                // Enabling in the first half of the period runs an extra tick.
                do_tick = (length_left_reg != '0) && !length_on_reg && flag_reg
                          && first_half_reg;
            end
            sclen_pkg::KIND_ENVELOPE:
            begin
                env_period_next = value_reg[sclen_pkg::PERIOD_W-1:0];
                env_count_next  = '0;
                env_up_next     = flag_reg;
                if (vol_reg == '0 && !flag_reg)
                begin
                    dac_on_next  = 1'b0;
                    chan_on_next = 1'b0;
                end
                else
                begin
                    dac_on_next = 1'b1;
                end
            end
            sclen_pkg::KIND_TRIGGER:
            begin
                if (length_left_reg == '0)
                begin
                    length_left_next = LIMIT_W;
                    do_tick          = just_en_reg;
                end
            end
            sclen_pkg::KIND_CHANNEL_EN:
            begin
                chan_on_next = flag_reg;
            end
            default:
            begin
            end
        endcase

        // Frame sequencer tick.
        if (do_tick)
        begin
            if (!dac_on_next)
                chan_on_next = 1'b0;
            phase_next = phase_reg + 1'b1;
            if (length_on_next && length_left_next != '0)
            begin
                length_left_next = length_left_next - 1'b1;
                if (length_left_next == '0)
                    chan_on_next = 1'b0;
            end
            if (phase_next == '0)
            begin
                if (env_count_next == 3'd1)
                begin
                    if (!env_up_next && vol_next != '0)
                        vol_next = vol_next - 1'b1;
                    else if (env_up_next && vol_next != sclen_pkg::VOL_MAX)
                        vol_next = vol_next + 1'b1;
                    env_count_next = env_period_next;
                end
                else if (env_count_next != '0)
                begin
                    env_count_next = env_count_next - 1'b1;
                end
            end
        end

        // A trigger reloads the envelope after any extra tick it caused.
        if (kind_reg == sclen_pkg::KIND_TRIGGER)
        begin
            env_count_next = env_period_next;
            vol_next       = start_vol_next;
            if (!dac_on_next)
                chan_on_next = 1'b0;
        end

        level = (chan_on_next && dac_on_next) ? vol_next : '0;
        out_data_next = {7'd0, 7'(length_left_next), dac_on_next, chan_on_next,
                         vol_next, level};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            chan_on_reg     <= 1'b1;
            dac_on_reg      <= 1'b1;
            length_on_reg   <= 1'b0;
            just_en_reg     <= 1'b0;
            length_left_reg <= LIMIT_W;
            vol_reg         <= sclen_pkg::VOL_MAX;
            start_vol_reg   <= sclen_pkg::VOL_MAX;
            env_period_reg  <= '0;
            env_up_reg      <= 1'b0;
            env_count_reg   <= '0;
            phase_reg       <= '0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                chan_on_reg     <= chan_on_next;
                dac_on_reg      <= dac_on_next;
                length_on_reg   <= length_on_next;
                just_en_reg     <= just_en_next;
                length_left_reg <= length_left_next;
                vol_reg         <= vol_next;
                start_vol_reg   <= start_vol_next;
                env_period_reg  <= env_period_next;
                env_up_reg      <= env_up_next;
                env_count_reg   <= env_count_next;
                phase_reg       <= phase_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            kind_reg       <= s_axis_tuser;
            value_reg      <= s_axis_tdata[6:0];
            flag_reg       <= s_axis_tdata[7];
            first_half_reg <= s_axis_tdata[8];
        end
        if (advance)
            out_data_reg <= out_data_next;
    end

endmodule

/* tb/tb.sv */
// Self-checking testbench for the sound channel length and envelope core.
`timescale 1ns / 1ps

module tb;

    localparam int LEN_LIMIT = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_REQS = 700;
    localparam sclen_pkg::kind_t KIND_NONE = 3'd7;

    typedef struct packed {
        sclen_pkg::kind_t                  kind;
        logic [sclen_pkg::VALUE_W-1:0]     value;
        logic                              flag;
        logic                              first_half;
    } chan_req_t;

    typedef struct packed {
        logic [sclen_pkg::VOL_W-1:0]       level;
        logic [sclen_pkg::VOL_W-1:0]       volume;
        logic                              active;
        logic                              dac;
        logic [sclen_pkg::VALUE_W-1:0]     remaining;
    } chan_status_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [sclen_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic [2:0]                        s_axis_tuser = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [sclen_pkg::OUT_W-1:0]       m_axis_tdata;

    chan_req_t    pending_reqs[$];
    chan_status_t awaited_status[$];
    chan_req_t    cur_req;
    int           total_reqs = 0;
    int           accepted = 0;
    int           errors = 0;
    int           cycles = 0;

    // Channel state as the core should hold it, starting from its reset values.
    logic         ch_en = 1'b1;
    logic         dac_en = 1'b1;
    logic         len_en = 1'b0;
    logic         len_armed = 1'b0;
    int           len_count = LEN_LIMIT;
    logic [3:0]   vol_now = sclen_pkg::VOL_MAX;
    logic [3:0]   vol_init = sclen_pkg::VOL_MAX;
    logic [2:0]   env_per = '0;
    logic         env_rise = 1'b0;
    logic [2:0]   env_cnt = '0;
    logic [1:0]   seq_phase = '0;

    sound_channel_length_envelope_core #(
        .LENGTH_LIMIT(LEN_LIMIT)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    function automatic void seq_advance();
        if (!dac_en)
            ch_en = 1'b0;
        seq_phase = seq_phase + 2'd1;
        if (len_en && len_count > 0)
        begin
            len_count = len_count - 1;
            if (len_count == 0)
                ch_en = 1'b0;
        end
        // The envelope is clocked once per four sequencer ticks.
        if (seq_phase == 2'd0)
        begin
            if (env_cnt == 3'd1)
            begin
                if (!env_rise && vol_now > 4'd0)
                    vol_now = vol_now - 4'd1;
                else if (env_rise && vol_now < sclen_pkg::VOL_MAX)
                    vol_now = vol_now + 4'd1;
                env_cnt = env_per;
            end
            else if (env_cnt != 3'd0)
            begin
                env_cnt = env_cnt - 3'd1;
            end
        end
    endfunction

    function automatic void apply_dac_rule();
        if (vol_now == 4'd0 && !env_rise)
        begin
            dac_en = 1'b0;
            ch_en = 1'b0;
        end
        else
        begin
            dac_en = 1'b1;
        end
    endfunction

    function automatic chan_status_t channel_step(chan_req_t r);
        chan_status_t st;
        logic         newly;
        int           load;
        case (r.kind)
            sclen_pkg::KIND_TICK:
                seq_advance();
            sclen_pkg::KIND_VOLUME:
            begin
                vol_now = r.value[3:0];
                vol_init = vol_now;
                if (r.flag)
                    apply_dac_rule();
            end
            sclen_pkg::KIND_LENGTH:
            begin
                load = (r.value > LEN_LIMIT) ? LEN_LIMIT : int'(r.value);
                len_count = LEN_LIMIT - load;
            end
            sclen_pkg::KIND_LENGTH_EN:
            begin
                newly = !len_en && r.flag;
                len_en = r.flag;
                len_armed = newly;
                // Enabling in the first half of the period runs an extra tick.
                if (len_count > 0 && newly && r.first_half)
                    seq_advance();
            end
            sclen_pkg::KIND_ENVELOPE:
            begin
                env_per = r.value[2:0];
                env_cnt = 3'd0;
                env_rise = r.flag;
                apply_dac_rule();
            end
            sclen_pkg::KIND_TRIGGER:
            begin
                if (len_count == 0)
                begin
                    len_count = LEN_LIMIT;
                    if (len_armed)
                        seq_advance();
                end
                env_cnt = env_per;
                vol_now = vol_init;
                // A trigger never turns the channel back on.
                if (!dac_en)
                    ch_en = 1'b0;
            end
            sclen_pkg::KIND_CHANNEL_EN:
                ch_en = r.flag;
            default:
                ;
        endcase
        st.level = (ch_en && dac_en) ? vol_now : 4'd0;
        st.volume = vol_now;
        st.active = ch_en;
        st.dac = dac_en;
        st.remaining = len_count[sclen_pkg::VALUE_W-1:0];
        return st;
    endfunction

    function automatic int idle_pct(bit sender);
        int stage;
        stage = (total_reqs == 0) ? 0 : accepted * 3 / total_reqs;
        case (stage)
            0:       return sender ? 26 : 62;
            1:       return sender ? 62 : 26;
            default: return 0;
        endcase
    endfunction

    task automatic push_req(sclen_pkg::kind_t kind, int value, bit flag, bit first_half);
        chan_req_t r;
        r.kind = kind;
        r.value = value[sclen_pkg::VALUE_W-1:0];
        r.flag = flag;
        r.first_half = first_half;
        pending_reqs.push_back(r);
    endtask

    task automatic check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                     exp_val, act_val);
            errors++;
        end
    endtask

    // Request driver: predicts each accepted request and presents the next one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                awaited_status.push_back(channel_step(cur_req));
                accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct(1'b1))
                begin
                    cur_req = pending_reqs.pop_front();
                    s_axis_tdata <= {7'b0, cur_req.first_half, cur_req.flag, cur_req.value};
                    s_axis_tuser <= cur_req.kind;
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        chan_status_t exp_st;
        chan_status_t act_st;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                act_st.level = m_axis_tdata[3:0];
                act_st.volume = m_axis_tdata[7:4];
                act_st.active = m_axis_tdata[8];
                act_st.dac = m_axis_tdata[9];
                act_st.remaining = m_axis_tdata[16:10];
                if (awaited_status.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time,
                             m_axis_tdata);
                    errors++;
                end
                else
                begin
                    exp_st = awaited_status.pop_front();
                    check_field("level", int'(exp_st.level), int'(act_st.level));
                    check_field("current_volume", int'(exp_st.volume),
                                int'(act_st.volume));
                    check_field("channel_active", int'(exp_st.active),
                                int'(act_st.active));
                    check_field("dac_active", int'(exp_st.dac), int'(act_st.dac));
                    check_field("length_remaining", int'(exp_st.remaining),
                                int'(act_st.remaining));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= idle_pct(1'b0));
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int   sel;
        int   value;
        bit   flag;
        sclen_pkg::kind_t kind;

        // Directed requests: unused kind, DAC on and off, length edge cases.
        push_req(KIND_NONE, 127, 1'b1, 1'b1);
        push_req(sclen_pkg::KIND_VOLUME, 127, 1'b0, 1'b0);
        push_req(sclen_pkg::KIND_VOLUME, 0, 1'b1, 1'b0);
        push_req(sclen_pkg::KIND_TICK, 0, 1'b0, 1'b0);
        push_req(sclen_pkg::KIND_ENVELOPE, 127, 1'b1, 1'b0);
        push_req(sclen_pkg::KIND_CHANNEL_EN, 0, 1'b1, 1'b0);
        push_req(sclen_pkg::KIND_VOLUME, 0, 1'b1, 1'b0);
        push_req(sclen_pkg::KIND_LENGTH, 127, 1'b0, 1'b0);
        push_req(sclen_pkg::KIND_TRIGGER, 0, 1'b0, 1'b0);
        push_req(sclen_pkg::KIND_LENGTH, 63, 1'b0, 1'b0);
        push_req(sclen_pkg::KIND_LENGTH_EN, 0, 1'b1, 1'b1);
        push_req(sclen_pkg::KIND_LENGTH_EN, 0, 1'b0, 1'b1);
        push_req(sclen_pkg::KIND_LENGTH, 64, 1'b0, 1'b0);
        push_req(sclen_pkg::KIND_LENGTH_EN, 0, 1'b1, 1'b0);
        push_req(sclen_pkg::KIND_TRIGGER, 0, 1'b0, 1'b0);
        push_req(sclen_pkg::KIND_CHANNEL_EN, 0, 1'b1, 1'b0);
        // Envelope saturation at the top, then at zero.
        push_req(sclen_pkg::KIND_VOLUME, 15, 1'b0, 1'b0);
        push_req(sclen_pkg::KIND_ENVELOPE, 1, 1'b1, 1'b0);
        push_req(sclen_pkg::KIND_TRIGGER, 0, 1'b0, 1'b0);
        repeat (4) push_req(sclen_pkg::KIND_TICK, 0, 1'b0, 1'b0);
        push_req(sclen_pkg::KIND_ENVELOPE, 1, 1'b0, 1'b0);
        push_req(sclen_pkg::KIND_VOLUME, 0, 1'b0, 1'b0);
        push_req(sclen_pkg::KIND_TRIGGER, 0, 1'b0, 1'b0);
        repeat (4) push_req(sclen_pkg::KIND_TICK, 0, 1'b0, 1'b0);

        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            sel = $urandom_range(99);
            value = $urandom_range(127);
            flag = 1'($urandom_range(1));
            if (sel < 38)
                kind = sclen_pkg::KIND_TICK;
            else if (sel < 48)
                kind = sclen_pkg::KIND_TRIGGER;
            else if (sel < 57)
            begin
                kind = sclen_pkg::KIND_LENGTH;
                // Mostly short lengths so the counter runs out during the run.
                if ($urandom_range(4) != 0)
                    value = $urandom_range(64, 40);
            end
            else if (sel < 65)
                kind = sclen_pkg::KIND_LENGTH_EN;
            else if (sel < 73)
            begin
                kind = sclen_pkg::KIND_ENVELOPE;
                if ($urandom_range(5) != 0)
                    value = $urandom_range(3);
            end
            else if (sel < 84)
            begin
                kind = sclen_pkg::KIND_VOLUME;
                if ($urandom_range(3) == 0)
                    value = 0;
                else if ($urandom_range(7) != 0)
                    value = $urandom_range(15);
            end
            else if (sel < 94)
            begin
                kind = sclen_pkg::KIND_CHANNEL_EN;
                flag = ($urandom_range(3) != 0);
            end
            else
                kind = KIND_NONE;
            push_req(kind, value, flag, 1'($urandom_range(1)));
        end
        total_reqs = pending_reqs.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        wait (accepted == total_reqs);
        wait (awaited_status.size() == 0);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sound_channel_length_envelope_core.f */
sv/sclen_pkg.sv
sv/sound_channel_length_envelope_core.sv
tb/tb.sv
